### sv/gfja_pkg.sv
// ---------------------------------------------------------------------------
// gfja_pkg: shared types and arithmetic for the gravity force/jerk unit
// Widths, opcodes, controller/datapath command and status structs, and the
// saturating helpers used by the datapath.
// ---------------------------------------------------------------------------
package gfja_pkg;

	localparam int COORD_W   = 48;
	localparam int SUM_W     = 64;
	localparam int MASS_W    = 32;
	localparam int SOFT_W    = 48;
	localparam int OUT_W     = 64;
	localparam int FUNC_W    = 2;
	localparam int WORD_W    = 64;
	localparam int HALF_W    = WORD_W / 2;
	localparam int PROD_W    = 2 * WORD_W;
	localparam int FRAC_W    = 40;
	localparam int MASS_FRAC = 32;
	localparam int LANES     = 3;
	localparam int LANE_W    = $clog2(LANES);

	localparam int MUL_STEPS   = 4;
	localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
	localparam int DIV_STEPS   = WORD_W + FRAC_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
	localparam int SQRT_STEPS  = WORD_W;
	localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS);
	localparam int SQRT_REM_W  = WORD_W + 4;
	localparam int ALPHA_DIVS  = 2;
	localparam int CHAIN_DIVS  = 3;

	localparam logic [SOFT_W-1:0] SOFT_RESET = SOFT_W'(109951163);

	// item function codes
	localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_EMIT = 2'd2;

	localparam logic signed [WORD_W-1:0] S64_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] S64_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic signed [67:0] S64_MAX_X = 68'(S64_MAX);
	localparam logic signed [67:0] S64_MIN_X = 68'(S64_MIN);
	localparam logic signed [67:0] SUM_MAX_X = 68'({1'b0, {(SUM_W-1){1'b1}}});
	localparam logic signed [67:0] SUM_MIN_X = -SUM_MAX_X - 68'sd1;
	localparam logic signed [65:0] DIFF_LIM_X = 66'sh3FFFFFFFFFFFFFFF;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIFF,
		OP_SQ,
		OP_DV,
		OP_FINR,
		OP_SQRT,
		OP_RV,
		OP_DIV,
		OP_ALPHA,
		OP_MULD,
		OP_MULV,
		OP_SAVEA,
		OP_MULP,
		OP_JSUB,
		OP_UPD,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t              op;
		logic                start;
		logic                capture;
		logic [LANE_W-1:0]   lane;
	} gfja_cmd_t;

	typedef struct packed {
		logic done;
		logic r_zero;
	} gfja_sts_t;

	// magnitude of a signed word (most negative maps to 2^63)
	function automatic logic [WORD_W-1:0] mag64(input logic signed [WORD_W-1:0] x);
		return x[WORD_W-1] ? WORD_W'(-x) : WORD_W'(x);
	endfunction

	// apply sign to a magnitude, saturating to a signed word
	function automatic logic signed [WORD_W-1:0] to_s64(input logic neg,
			input logic [PROD_W-1:0] m);
		logic signed [WORD_W-1:0] v;
		v = $signed(m[WORD_W-1:0]);
		if (|m[PROD_W-1:WORD_W-1]) return neg ? S64_MIN : S64_MAX;
		return neg ? -v : v;
	endfunction

	function automatic logic signed [WORD_W-1:0] clamp64(input logic signed [67:0] v);
		if (v > S64_MAX_X) return S64_MAX;
		if (v < S64_MIN_X) return S64_MIN;
		return v[WORD_W-1:0];
	endfunction

	function automatic logic signed [SUM_W-1:0] clamp_sum(input logic signed [67:0] v);
		if (v > SUM_MAX_X) return SUM_MAX_X[SUM_W-1:0];
		if (v < SUM_MIN_X) return SUM_MIN_X[SUM_W-1:0];
		return v[SUM_W-1:0];
	endfunction

	function automatic logic signed [WORD_W-1:0] clamp_diff(input logic signed [65:0] v);
		if (v > DIFF_LIM_X) return DIFF_LIM_X[WORD_W-1:0];
		if (v < -DIFF_LIM_X) return WORD_W'(-DIFF_LIM_X);
		return v[WORD_W-1:0];
	endfunction

endpackage

### sv/gfja_ifs.sv
// ---------------------------------------------------------------------------
// gfja_ifs: item and result channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ---------------------------------------------------------------------------
interface gfja_item_if import gfja_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [FUNC_W-1:0]          func;
	logic signed [COORD_W-1:0]  pos_x;
	logic signed [COORD_W-1:0]  pos_y;
	logic signed [COORD_W-1:0]  pos_z;
	logic signed [COORD_W-1:0]  vel_x;
	logic signed [COORD_W-1:0]  vel_y;
	logic signed [COORD_W-1:0]  vel_z;
	logic [MASS_W-1:0]          mass;

	modport source (output valid, func, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, mass,
		input ready);
	modport sink (input valid, func, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, mass,
		output ready);
endinterface

interface gfja_result_if import gfja_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [OUT_W-1:0]  acc_x;
	logic signed [OUT_W-1:0]  acc_y;
	logic signed [OUT_W-1:0]  acc_z;
	logic signed [OUT_W-1:0]  jerk_x;
	logic signed [OUT_W-1:0]  jerk_y;
	logic signed [OUT_W-1:0]  jerk_z;

	modport source (output valid, acc_x, acc_y, acc_z, jerk_x, jerk_y, jerk_z,
		input ready);
	modport sink (input valid, acc_x, acc_y, acc_z, jerk_x, jerk_y, jerk_z,
		output ready);
endinterface

### sv/gravity_force_jerk_accumulator_unit.sv
// ---------------------------------------------------------------------------
// gravity_force_jerk_accumulator_unit: softened gravity acc/jerk pair kernel
// Accumulates acceleration and jerk on one target over a stream of sources.
// ---------------------------------------------------------------------------
// Usage:
//   item   : valid/ready channel. func 0 loads the target position and
//            velocity and clears both sums. func 1 adds one source;
//            func 2 adds one source and then presents both sums on result.
//            func 3 is dropped in the cycle it is taken.
//   result : valid/ready channel carrying the saturated sums; one output
//            register, so the block works on the next item while a result
//            waits, and only stalls before it would overwrite it.
//   cfg    : cfg_we writes softening_squared from cfg_wdata; write while idle.
// For a source item the shared 104-step divider runs 20 times (two for the
// r.v term, three per axis for each of acceleration and jerk), plus a
// 64-step square root and 15 four-step multiplies.
// A source with zero softened distance skips the root and adds nothing.
// Only one item is in flight; item.ready is high when the sequencer idles.
// Reset clears the target, the sums and the result valid, and restores the
// default softening.
// ---------------------------------------------------------------------------
module gravity_force_jerk_accumulator_unit import gfja_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	gfja_item_if.sink            item,
	gfja_result_if.source        result,
	input  logic                 cfg_we,
	input  logic [SOFT_W-1:0]    cfg_wdata
);

	gfja_cmd_t cmd;
	gfja_sts_t sts;

	gfja_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.func      (item.func),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	gfja_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.pos_x     (item.pos_x),
		.pos_y     (item.pos_y),
		.pos_z     (item.pos_z),
		.vel_x     (item.vel_x),
		.vel_y     (item.vel_y),
		.vel_z     (item.vel_z),
		.mass      (item.mass),
		.acc_x     (result.acc_x),
		.acc_y     (result.acc_y),
		.acc_z     (result.acc_z),
		.jerk_x    (result.jerk_x),
		.jerk_y    (result.jerk_y),
		.jerk_z    (result.jerk_z)
	);

`ifndef SYNTHESIS
	// a unit finishes only while the sequencer waits on a unit operation
	a_done_in_unit_op: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> (cmd.op == OP_SQ || cmd.op == OP_DV || cmd.op == OP_SQRT ||
			cmd.op == OP_DIV || cmd.op == OP_MULD || cmd.op == OP_MULV ||
			cmd.op == OP_MULP))
		else $error("unit done outside a unit operation");

	// a source item always occupies the sequencer past its transfer
	a_busy_after_source: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && (item.func == FUNC_ADD || item.func == FUNC_EMIT))
		|=> !item.ready)
		else $error("ready right after a source transfer");

	// start pulses are single cycle
	a_start_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !cmd.start)
		else $error("start held for two cycles");
`endif

endmodule

### sv/gfja_mul.sv
// ---------------------------------------------------------------------------
// gfja_mul: 64x64 unsigned multiplier
// One 32x32 partial product per cycle, summed over four steps per product.
// ---------------------------------------------------------------------------
module gfja_mul import gfja_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [WORD_W-1:0]   a,
	input  logic [WORD_W-1:0]   b,
	output logic                done,
	output logic [PROD_W-1:0]   prod
);

	logic [WORD_W-1:0]    a_q, b_q;
	logic [PROD_W-1:0]    acc_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q, done_q;
	logic [HALF_W-1:0]    ah, bh;
	logic [WORD_W-1:0]    pp;
	logic [PROD_W-1:0]    pp_sh;

	// pick the halves for this step and place the partial product
	always_comb begin
		ah = cnt_q[0] ? a_q[WORD_W-1:HALF_W] : a_q[HALF_W-1:0];
		bh = cnt_q[1] ? b_q[WORD_W-1:HALF_W] : b_q[HALF_W-1:0];
		pp = WORD_W'(ah) * WORD_W'(bh);
		case ({cnt_q[1], cnt_q[0]})
			2'b00:   pp_sh = PROD_W'(pp);
			2'b11:   pp_sh = PROD_W'(pp) << WORD_W;
			default: pp_sh = PROD_W'(pp) << HALF_W;
		endcase
	end

	// sequence the four steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// hold operands and accumulate
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

### sv/gfja_div.sv
// ---------------------------------------------------------------------------
// gfja_div: restoring divider for (num * 2^40) / den
// One quotient bit per cycle; flags a quotient that does not fit 64 bits.
// ---------------------------------------------------------------------------
module gfja_div import gfja_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [WORD_W-1:0]   num,
	input  logic [WORD_W-1:0]   den,
	output logic                done,
	output logic [WORD_W-1:0]   quo,
	output logic                ovf
);

	logic [WORD_W-1:0]    num_q, den_q, rem_q, quo_q;
	logic                 ovf_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q, done_q;
	logic [WORD_W-1:0]    trial, rem_n;
	logic                 ge;

	// one restoring step, shifting in the next numerator bit
	always_comb begin
		trial = {rem_q[WORD_W-2:0], num_q[WORD_W-1]};
		ge    = rem_q[WORD_W-1] | (trial >= den_q);
		rem_n = ge ? trial - den_q : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= rem_n;
			quo_q <= {quo_q[WORD_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[WORD_W-1];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign ovf  = ovf_q;

endmodule

### sv/gfja_sqrt.sv
// ---------------------------------------------------------------------------
// gfja_sqrt: integer square root of rad * 2^40
// Digit-by-digit method, one root bit per cycle.
// ---------------------------------------------------------------------------
module gfja_sqrt import gfja_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [WORD_W-1:0]   rad,
	output logic                done,
	output logic [WORD_W-1:0]   root
);

	logic [PROD_W-1:0]     x_q;
	logic [SQRT_REM_W-1:0] rem_q, rem_sh, trial;
	logic [WORD_W-1:0]     root_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic                  busy_q, done_q;
	logic                  ge;

	// bring down two radicand bits and try the next root bit
	always_comb begin
		rem_sh = {rem_q[SQRT_REM_W-3:0], x_q[PROD_W-1:PROD_W-2]};
		trial  = {2'b00, root_q, 2'b01};
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQRT_CNT_W'(SQRT_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= PROD_W'(rad) << FRAC_W;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= x_q << 2;
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[WORD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### sv/gfja_dp.sv
// ---------------------------------------------------------------------------
// gfja_dp: datapath of the gravity force/jerk unit
// Target and sum registers, work registers, and the shared multiply,
// divide and square-root units, driven one operation at a time.
// ---------------------------------------------------------------------------
module gfja_dp import gfja_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [SOFT_W-1:0]          cfg_wdata,
	input  gfja_cmd_t                  cmd,
	output gfja_sts_t                  sts,
	input  logic signed [COORD_W-1:0]  pos_x,
	input  logic signed [COORD_W-1:0]  pos_y,
	input  logic signed [COORD_W-1:0]  pos_z,
	input  logic signed [COORD_W-1:0]  vel_x,
	input  logic signed [COORD_W-1:0]  vel_y,
	input  logic signed [COORD_W-1:0]  vel_z,
	input  logic [MASS_W-1:0]          mass,
	output logic signed [OUT_W-1:0]    acc_x,
	output logic signed [OUT_W-1:0]    acc_y,
	output logic signed [OUT_W-1:0]    acc_z,
	output logic signed [OUT_W-1:0]    jerk_x,
	output logic signed [OUT_W-1:0]    jerk_y,
	output logic signed [OUT_W-1:0]    jerk_z
);

	logic [SOFT_W-1:0]         soft_q;
	logic signed [COORD_W-1:0] tpos_q [LANES];
	logic signed [COORD_W-1:0] tvel_q [LANES];
	logic signed [SUM_W-1:0]   acc_q  [LANES];
	logic signed [SUM_W-1:0]   jrk_q  [LANES];

	logic signed [COORD_W-1:0] ipos_q [LANES];
	logic signed [COORD_W-1:0] ivel_q [LANES];
	logic [MASS_W-1:0]         mass_q;
	logic signed [WORD_W-1:0]  d_q    [LANES];
	logic signed [WORD_W-1:0]  dv_q   [LANES];
	logic [PROD_W-1:0]         s2_q, pos_q, neg_q;
	logic [WORD_W-1:0]         r2_q, root_q;
	logic signed [WORD_W-1:0]  w_q, alpha_q, a_q, p_q;
	logic signed [OUT_W-1:0]   out_acc_q [LANES];
	logic signed [OUT_W-1:0]   out_jrk_q [LANES];

	logic [LANE_W-1:0]   l;
	logic                mul_start, div_start, sqrt_start;
	logic [WORD_W-1:0]   mul_a, mul_b;
	logic                mul_done, div_done, sqrt_done, div_ovf;
	logic [PROD_W-1:0]   prod;
	logic [WORD_W-1:0]   quo, root;
	logic [PROD_W-1:0]   s2_sh, rv_diff;
	logic [WORD_W-1:0]   r2_sat, r2_sum;
	logic [WORD_W:0]     r2_add;
	logic                rv_neg;
	logic signed [WORD_W-1:0] rv, p3;

	assign l = cmd.lane;

	// select multiplier operands for the current operation
	always_comb begin
		mul_a = mag64(d_q[l]);
		mul_b = mag64(d_q[l]);
		case (cmd.op)
			OP_DV:   mul_b = mag64(dv_q[l]);
			OP_MULD: mul_b = WORD_W'(mass_q);
			OP_MULV: begin
				mul_a = mag64(dv_q[l]);
				mul_b = WORD_W'(mass_q);
			end
			OP_MULP: begin
				mul_a = mag64(alpha_q);
				mul_b = mag64(a_q);
			end
			default: ;
		endcase
	end

	assign mul_start  = cmd.start && (cmd.op inside {OP_SQ, OP_DV, OP_MULD, OP_MULV, OP_MULP});
	assign div_start  = cmd.start && (cmd.op == OP_DIV);
	assign sqrt_start = cmd.start && (cmd.op == OP_SQRT);

	gfja_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	gfja_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mag64(w_q)),
		.den    (root_q),
		.done   (div_done),
		.quo    (quo),
		.ovf    (div_ovf)
	);

	gfja_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (r2_q),
		.done   (sqrt_done),
		.root   (root)
	);

	// softened squared distance, saturated
	always_comb begin
		s2_sh  = s2_q >> FRAC_W;
		r2_sat = (|s2_sh[PROD_W-1:WORD_W]) ? '1 : s2_sh[WORD_W-1:0];
		r2_add = {1'b0, r2_sat} + (WORD_W+1)'(soft_q);
		r2_sum = r2_add[WORD_W] ? '1 : r2_add[WORD_W-1:0];
	end

	// scaled r.v from the split positive and negative sums
	always_comb begin
		rv_neg  = pos_q < neg_q;
		rv_diff = rv_neg ? neg_q - pos_q : pos_q - neg_q;
		rv      = to_s64(rv_neg, rv_diff >> FRAC_W);
		p3      = clamp64(68'(p_q) + 68'(p_q) + 68'(p_q));
	end

	assign sts.done   = mul_done | div_done | sqrt_done;
	assign sts.r_zero = (r2_q == '0);

	// target, sums and softening register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soft_q <= SOFT_RESET;
			for (int k = 0; k < LANES; k++) begin
				tpos_q[k] <= '0;
				tvel_q[k] <= '0;
				acc_q[k]  <= '0;
				jrk_q[k]  <= '0;
			end
		end else begin
			if (cfg_we) soft_q <= cfg_wdata;
			case (cmd.op)
				OP_LOAD: begin
					for (int k = 0; k < LANES; k++) begin
						tpos_q[k] <= ipos_q[k];
						tvel_q[k] <= ivel_q[k];
						acc_q[k]  <= '0;
						jrk_q[k]  <= '0;
					end
				end
				OP_UPD: begin
					acc_q[l] <= clamp_sum(68'(acc_q[l]) + 68'(a_q));
					jrk_q[l] <= clamp_sum(68'(jrk_q[l]) + 68'(w_q));
				end
				default: ;
			endcase
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ipos_q[0] <= pos_x;
			ipos_q[1] <= pos_y;
			ipos_q[2] <= pos_z;
			ivel_q[0] <= vel_x;
			ivel_q[1] <= vel_y;
			ivel_q[2] <= vel_z;
			mass_q    <= mass;
		end
		case (cmd.op)
			OP_DIFF: begin
				for (int k = 0; k < LANES; k++) begin
					d_q[k]  <= clamp_diff(66'(ipos_q[k]) - 66'(tpos_q[k]));
					dv_q[k] <= clamp_diff(66'(ivel_q[k]) - 66'(tvel_q[k]));
				end
				s2_q  <= '0;
				pos_q <= '0;
				neg_q <= '0;
			end
			OP_SQ: if (mul_done) s2_q <= s2_q + prod;
			OP_DV: begin
				if (mul_done) begin
					if (d_q[l][WORD_W-1] ^ dv_q[l][WORD_W-1]) neg_q <= neg_q + prod;
					else pos_q <= pos_q + prod;
				end
			end
			OP_FINR: r2_q <= r2_sum;
			OP_SQRT: if (sqrt_done) root_q <= root;
			OP_RV:   w_q <= rv;
			OP_DIV: begin
				if (div_done) begin
					w_q <= to_s64(w_q[WORD_W-1],
						{{(PROD_W-WORD_W-1){1'b0}}, div_ovf, quo});
				end
			end
			OP_ALPHA: alpha_q <= w_q;
			OP_MULD: if (mul_done) w_q <= to_s64(d_q[l][WORD_W-1], prod >> MASS_FRAC);
			OP_MULV: if (mul_done) w_q <= to_s64(dv_q[l][WORD_W-1], prod >> MASS_FRAC);
			OP_SAVEA: a_q <= w_q;
			OP_MULP: begin
				if (mul_done) begin
					p_q <= to_s64(alpha_q[WORD_W-1] ^ a_q[WORD_W-1], prod >> FRAC_W);
				end
			end
			OP_JSUB: w_q <= clamp64(68'(w_q) - 68'(p3));
			OP_EMIT: begin
				for (int k = 0; k < LANES; k++) begin
					out_acc_q[k] <= OUT_W'(acc_q[k]);
					out_jrk_q[k] <= OUT_W'(jrk_q[k]);
				end
			end
			default: ;
		endcase
	end

	assign acc_x  = out_acc_q[0];
	assign acc_y  = out_acc_q[1];
	assign acc_z  = out_acc_q[2];
	assign jerk_x = out_jrk_q[0];
	assign jerk_y = out_jrk_q[1];
	assign jerk_z = out_jrk_q[2];

endmodule

### sv/gfja_ctrl.sv
// ---------------------------------------------------------------------------
// gfja_ctrl: sequencer of the gravity force/jerk unit
// Walks one source through difference, distance, square root, divide
// chains and accumulation; owns the input ready and the result valid.
// ---------------------------------------------------------------------------
module gfja_ctrl import gfja_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [FUNC_W-1:0]  func,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output gfja_cmd_t          cmd,
	input  gfja_sts_t          sts
);

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_DIFF, S_SQ, S_DV, S_FINR, S_CHKR, S_SQRT, S_RV,
		S_DIVA, S_ALPHA, S_MULD, S_DIVD, S_SAVEA, S_MULV, S_DIVV, S_MULP,
		S_JSUB, S_UPD, S_EMIT
	} state_t;

	state_t            state_q;
	logic [LANE_W-1:0] lane_q;
	logic [1:0]        rep_q;
	logic              run_q, emit_q, out_valid_q;
	logic              accept, unit_st, step_done, emit_go, last_lane;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign unit_st   = state_q inside {S_SQ, S_DV, S_SQRT, S_DIVA, S_MULD, S_DIVD,
		S_MULV, S_DIVV, S_MULP};
	assign step_done = run_q && sts.done;
	assign emit_go   = (state_q == S_EMIT) && (!out_valid_q || out_ready);
	assign last_lane = (lane_q == LANE_W'(LANES - 1));
	assign out_valid = out_valid_q;

	// decode the datapath command
	always_comb begin
		cmd.capture = accept;
		cmd.lane    = lane_q;
		cmd.start   = unit_st && !run_q;
		case (state_q)
			S_LOAD:  cmd.op = OP_LOAD;
			S_DIFF:  cmd.op = OP_DIFF;
			S_SQ:    cmd.op = OP_SQ;
			S_DV:    cmd.op = OP_DV;
			S_FINR:  cmd.op = OP_FINR;
			S_SQRT:  cmd.op = OP_SQRT;
			S_RV:    cmd.op = OP_RV;
			S_DIVA, S_DIVD, S_DIVV: cmd.op = OP_DIV;
			S_ALPHA: cmd.op = OP_ALPHA;
			S_MULD:  cmd.op = OP_MULD;
			S_SAVEA: cmd.op = OP_SAVEA;
			S_MULV:  cmd.op = OP_MULV;
			S_MULP:  cmd.op = OP_MULP;
			S_JSUB:  cmd.op = OP_JSUB;
			S_UPD:   cmd.op = OP_UPD;
			S_EMIT:  cmd.op = emit_go ? OP_EMIT : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	// state, counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lane_q      <= '0;
			rep_q       <= '0;
			run_q       <= 1'b0;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			if (unit_st && !run_q) run_q <= 1'b1;
			if (step_done) run_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == FUNC_LOAD) begin
							state_q <= S_LOAD;
						end else if (func == FUNC_ADD || func == FUNC_EMIT) begin
							state_q <= S_DIFF;
							emit_q  <= (func == FUNC_EMIT);
						end
					end
				end
				S_LOAD: state_q <= S_IDLE;
				S_DIFF: begin
					lane_q  <= '0;
					state_q <= S_SQ;
				end
				S_SQ: if (step_done) state_q <= S_DV;
				S_DV: begin
					if (step_done) begin
						if (last_lane) begin
							lane_q  <= '0;
							state_q <= S_FINR;
						end else begin
							lane_q  <= lane_q + 1'b1;
							state_q <= S_SQ;
						end
					end
				end
				S_FINR: state_q <= S_CHKR;
				S_CHKR: begin
					// coincident particles with no softening add nothing
					if (sts.r_zero) state_q <= emit_q ? S_EMIT : S_IDLE;
					else state_q <= S_SQRT;
				end
				S_SQRT: if (step_done) state_q <= S_RV;
				S_RV: begin
					rep_q   <= '0;
					state_q <= S_DIVA;
				end
				S_DIVA: begin
					if (step_done) begin
						if (rep_q == 2'(ALPHA_DIVS - 1)) state_q <= S_ALPHA;
						else rep_q <= rep_q + 1'b1;
					end
				end
				S_ALPHA: begin
					lane_q  <= '0;
					state_q <= S_MULD;
				end
				S_MULD: begin
					if (step_done) begin
						rep_q   <= '0;
						state_q <= S_DIVD;
					end
				end
				S_DIVD: begin
					if (step_done) begin
						if (rep_q == 2'(CHAIN_DIVS - 1)) state_q <= S_SAVEA;
						else rep_q <= rep_q + 1'b1;
					end
				end
				S_SAVEA: state_q <= S_MULV;
				S_MULV: begin
					if (step_done) begin
						rep_q   <= '0;
						state_q <= S_DIVV;
					end
				end
				S_DIVV: begin
					if (step_done) begin
						if (rep_q == 2'(CHAIN_DIVS - 1)) state_q <= S_MULP;
						else rep_q <= rep_q + 1'b1;
					end
				end
				S_MULP: if (step_done) state_q <= S_JSUB;
				S_JSUB: state_q <= S_UPD;
				S_UPD: begin
					if (last_lane) begin
						state_q <= emit_q ? S_EMIT : S_IDLE;
					end else begin
						lane_q  <= lane_q + 1'b1;
						state_q <= S_MULD;
					end
				end
				S_EMIT: if (emit_go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### tb/gfja_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gfja_checker: result predictor and scoreboard for the gravity acc/jerk unit
// Watches the item, result and softening write ports, predicts the saturated
// acceleration and jerk sums for every emit item and compares each result
// transfer, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module gfja_checker import gfja_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	gfja_item_if              item,
	gfja_result_if            result,
	input  logic              cfg_we,
	input  logic [SOFT_W-1:0] cfg_wdata,
	output int                mismatches,
	output int                pending
);

	typedef logic signed [WORD_W-1:0] s64_t;
	typedef logic [PROD_W-1:0]        u128_t;

	typedef struct {
		s64_t acc[LANES];
		s64_t jrk[LANES];
	} sums_t;

	sums_t             sums_q[$];
	s64_t              tgt_pos[LANES];
	s64_t              tgt_vel[LANES];
	s64_t              acc_sum[LANES];
	s64_t              jrk_sum[LANES];
	logic [SOFT_W-1:0] soft_sq;

	assign pending = sums_q.size();

	function automatic logic [WORD_W-1:0] magn(s64_t x);
		return x < 0 ? WORD_W'(-x) : WORD_W'(x);
	endfunction

	// apply sign to a wide magnitude, saturating to 64 bits
	function automatic s64_t to_sat(logic neg, u128_t m);
		if (|m[PROD_W-1:WORD_W-1]) return neg ? S64_MIN : S64_MAX;
		return neg ? -$signed(m[WORD_W-1:0]) : $signed(m[WORD_W-1:0]);
	endfunction

	function automatic s64_t sat_add(s64_t a, s64_t b);
		logic [WORD_W:0] s;
		s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? S64_MIN : S64_MAX;
		return s[WORD_W-1:0];
	endfunction

	function automatic s64_t sat_sub(s64_t a, s64_t b);
		logic [WORD_W:0] s;
		s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? S64_MIN : S64_MAX;
		return s[WORD_W-1:0];
	endfunction

	// difference clamped to +-(2^62 - 1)
	function automatic s64_t diff_lim(s64_t a, s64_t b);
		logic signed [65:0] d;
		d = 66'(a) - 66'(b);
		if (d > DIFF_LIM_X) return DIFF_LIM_X[WORD_W-1:0];
		if (d < -DIFF_LIM_X) return WORD_W'(-DIFF_LIM_X);
		return d[WORD_W-1:0];
	endfunction

	function automatic s64_t mul_trunc(s64_t a, s64_t b, int n);
		u128_t p;
		p = {64'd0, magn(a)} * {64'd0, magn(b)};
		return to_sat((a < 0) != (b < 0), p >> n);
	endfunction

	// trunc(a * 2^40 / r)
	function automatic s64_t div_dist(s64_t a, logic [WORD_W-1:0] r);
		u128_t num;
		num = {64'd0, magn(a)} << FRAC_W;
		return to_sat(a < 0, num / {64'd0, r});
	endfunction

	function automatic logic [WORD_W-1:0] int_sqrt(u128_t x);
		logic [WORD_W-1:0] res;
		logic [WORD_W-1:0] c;
		res = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			c = res | (64'd1 << b);
			if (!(x < {64'd0, c} * {64'd0, c})) res = c;
		end
		return res;
	endfunction

	function automatic s64_t cube_div(s64_t x, logic [WORD_W-1:0] r);
		return div_dist(div_dist(div_dist(x, r), r), r);
	endfunction

	// add one source's softened contribution to both sums
	task automatic add_source(s64_t px[LANES], s64_t vx[LANES], logic [MASS_W-1:0] m);
		s64_t              d[LANES];
		s64_t              dv[LANES];
		u128_t             s2, ps, ng, p;
		logic [WORD_W-1:0] rr, r;
		s64_t              rv, alpha, a, jv, pa, p3, mass;
		logic              rneg;
		s2 = '0;
		ps = '0;
		ng = '0;
		mass = {32'd0, m};
		for (int k = 0; k < LANES; k++) begin
			d[k] = diff_lim(px[k], tgt_pos[k]);
			dv[k] = diff_lim(vx[k], tgt_vel[k]);
			s2 += {64'd0, magn(d[k])} * {64'd0, magn(d[k])};
			p = {64'd0, magn(d[k])} * {64'd0, magn(dv[k])};
			if ((d[k] < 0) != (dv[k] < 0)) ng += p;
			else ps += p;
		end
		s2 = s2 >> FRAC_W;
		rr = |s2[PROD_W-1:WORD_W] ? '1 : s2[WORD_W-1:0];
		rr = (rr > ~64'(soft_sq)) ? '1 : rr + 64'(soft_sq);
		// coincident particles with no softening add nothing
		if (rr == 0) return;
		r = int_sqrt({64'd0, rr} << FRAC_W);
		rneg = ps < ng;
		rv = to_sat(rneg, (rneg ? ng - ps : ps - ng) >> FRAC_W);
		alpha = div_dist(div_dist(rv, r), r);
		for (int k = 0; k < LANES; k++) begin
			a = cube_div(mul_trunc(d[k], mass, MASS_FRAC), r);
			jv = cube_div(mul_trunc(dv[k], mass, MASS_FRAC), r);
			pa = mul_trunc(alpha, a, FRAC_W);
			p3 = sat_add(sat_add(pa, pa), pa);
			acc_sum[k] = sat_add(acc_sum[k], a);
			jrk_sum[k] = sat_add(jrk_sum[k], sat_sub(jv, p3));
		end
	endtask

	task automatic check_field(string nm, s64_t exp_v, s64_t got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %h, got %h", nm, exp_v, got_v);
		end
	endtask

	// track state, predict on item transfers, compare on result transfers
	always @(posedge clk or negedge arst_n) begin
		s64_t  px[LANES];
		s64_t  vx[LANES];
		sums_t s;
		if (!arst_n) begin
			for (int k = 0; k < LANES; k++) begin
				tgt_pos[k] = 0;
				tgt_vel[k] = 0;
				acc_sum[k] = 0;
				jrk_sum[k] = 0;
			end
			soft_sq = SOFT_RESET;
			sums_q.delete();
			mismatches = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (sums_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: result with none expected");
				end else begin
					s = sums_q.pop_front();
					check_field("acc_x", s.acc[0], result.acc_x);
					check_field("acc_y", s.acc[1], result.acc_y);
					check_field("acc_z", s.acc[2], result.acc_z);
					check_field("jerk_x", s.jrk[0], result.jerk_x);
					check_field("jerk_y", s.jrk[1], result.jerk_y);
					check_field("jerk_z", s.jrk[2], result.jerk_z);
				end
			end
			if (item.valid && item.ready) begin
				px[0] = item.pos_x;
				px[1] = item.pos_y;
				px[2] = item.pos_z;
				vx[0] = item.vel_x;
				vx[1] = item.vel_y;
				vx[2] = item.vel_z;
				if (item.func == FUNC_LOAD) begin
					for (int k = 0; k < LANES; k++) begin
						tgt_pos[k] = px[k];
						tgt_vel[k] = vx[k];
						acc_sum[k] = 0;
						jrk_sum[k] = 0;
					end
				end else if (item.func == FUNC_ADD || item.func == FUNC_EMIT) begin
					add_source(px, vx, item.mass);
					if (item.func == FUNC_EMIT) begin
						s.acc = acc_sum;
						s.jrk = jrk_sum;
						sums_q.push_back(s);
					end
				end
			end
			if (cfg_we) soft_sq = cfg_wdata;
		end
	end

endmodule

### tb/tb_gravity_force_jerk_accumulator_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_gravity_force_jerk_accumulator_unit: stimulus and verdict
// Drives load/add/emit sequences with random gaps and result stalls over
// several softening settings; the checker predicts and compares results.
// ---------------------------------------------------------------------------
module tb_gravity_force_jerk_accumulator_unit;
	import gfja_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
	localparam int  LIMIT       = 10_000_000;
	localparam int  DRAIN_WAIT  = 3000;
	localparam int  ITEM_TARGET = 600;

	typedef logic signed [COORD_W-1:0] crd_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [SOFT_W-1:0] cfg_wdata;
	int                mismatches;
	int                pending;
	int                cycles;
	int                sent;
	int                tx_max_gap;
	int                rx_max_gap;
	crd_t              tgt_p[3];
	crd_t              tgt_v[3];

	gfja_item_if   item_ch();
	gfja_result_if result_ch();

	gravity_force_jerk_accumulator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	gfja_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// stall the result side at random
	initial begin
		int gap;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = rx_max_gap > 0 ? $urandom_range(0, rx_max_gap) : 0;
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	function automatic crd_t rand48();
		return crd_t'({$urandom, $urandom});
	endfunction

	// mostly near the center, sometimes anywhere or at an extreme
	function automatic crd_t pick_coord(crd_t ctr);
		logic signed [63:0] off;
		case ($urandom_range(0, 9))
			0, 1: return rand48();
			2: begin
				case ($urandom_range(0, 3))
					0: return {1'b0, {(COORD_W-1){1'b1}}};
					1: return {1'b1, {(COORD_W-1){1'b0}}};
					2: return '0;
					default: return '1;
				endcase
			end
			default: begin
				off = $signed({$urandom, $urandom});
				off = off >>> $urandom_range(18, 30);
				return crd_t'(ctr + off);
			end
		endcase
	endfunction

	function automatic logic [MASS_W-1:0] pick_mass();
		case ($urandom_range(0, 5))
			0: return '1;
			1: return '0;
			2: return $urandom >> $urandom_range(8, 28);
			default: return $urandom;
		endcase
	endfunction

	// hold the item until its transfer
	task automatic send(logic [FUNC_W-1:0] f, crd_t px, crd_t py, crd_t pz,
			crd_t vx, crd_t vy, crd_t vz, logic [MASS_W-1:0] m);
		int gap;
		gap = tx_max_gap > 0 ? $urandom_range(0, tx_max_gap) : 0;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.func  <= f;
		item_ch.pos_x <= px;
		item_ch.pos_y <= py;
		item_ch.pos_z <= pz;
		item_ch.vel_x <= vx;
		item_ch.vel_y <= vy;
		item_ch.vel_z <= vz;
		item_ch.mass  <= m;
		do @(posedge clk); while (!item_ch.ready);
		if (f != FUNC_NONE) sent++;
	endtask

	task automatic load_target(crd_t px, crd_t py, crd_t pz, crd_t vx, crd_t vy, crd_t vz);
		tgt_p = '{px, py, pz};
		tgt_v = '{vx, vy, vz};
		send(FUNC_LOAD, px, py, pz, vx, vy, vz, $urandom);
	endtask

	task automatic send_source(logic [FUNC_W-1:0] f);
		send(f, pick_coord(tgt_p[0]), pick_coord(tgt_p[1]), pick_coord(tgt_p[2]),
			pick_coord(tgt_v[0]), pick_coord(tgt_v[1]), pick_coord(tgt_v[2]), pick_mass());
	endtask

	// drain all results, let a trailing add finish, then write softening
	task automatic set_soft(logic [SOFT_W-1:0] v);
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	localparam crd_t CMAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam crd_t CMIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam crd_t ONE  = crd_t'(64'd1 << FRAC_W);

	initial begin
		int n;
		logic [SOFT_W-1:0] sv;
		cycles = 0;
		sent = 0;
		tx_max_gap = 10;
		rx_max_gap = 10;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.func  <= FUNC_LOAD;
		item_ch.pos_x <= '0;
		item_ch.pos_y <= '0;
		item_ch.pos_z <= '0;
		item_ch.vel_x <= '0;
		item_ch.vel_y <= '0;
		item_ch.vel_z <= '0;
		item_ch.mass  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes under reset softening
		load_target('0, '0, '0, '0, '0, '0);
		send(FUNC_EMIT, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, '1);
		send(FUNC_EMIT, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, '1);
		send(FUNC_ADD, ONE, '0, '0, '0, ONE, '0, 32'h8000_0000);
		send(FUNC_NONE, CMAX, CMIN, ONE, CMAX, CMIN, ONE, '1);
		// sums are kept after an emit
		send(FUNC_EMIT, '0, ONE, -ONE, ONE, '0, '0, 32'h1000_0000);
		send(FUNC_EMIT, '0, '0, ONE, '0, '0, -ONE, '0);
		load_target(CMAX, CMIN, '0, CMIN, CMAX, '1);
		send(FUNC_EMIT, CMIN, CMAX, '1, CMAX, CMIN, '0, '1);
		send(FUNC_EMIT, CMAX, CMIN, '0, CMIN, CMAX, '1, 32'd1);

		// directed: zero softening, coincident source adds nothing
		set_soft('0);
		load_target(ONE, -ONE, ONE, ONE, '0, -ONE);
		send(FUNC_EMIT, ONE, -ONE, ONE, CMAX, CMIN, '0, '1);
		send(FUNC_EMIT, ONE + 1, -ONE, ONE, '0, '0, '0, '1);
		send(FUNC_EMIT, ONE, -ONE, ONE, ONE, '0, -ONE, 32'h4000_0000);

		// directed: largest softening
		set_soft('1);
		load_target('0, '0, '0, '0, '0, '0);
		send(FUNC_EMIT, CMAX, CMIN, ONE, ONE, CMAX, CMIN, '1);
		send(FUNC_EMIT, ONE, ONE, ONE, ONE, ONE, ONE, '1);
		set_soft(SOFT_RESET);

		// random sequences over several settings and idling modes
		n = 0;
		while (sent < ITEM_TARGET) begin
			n++;
			if (n % 15 == 0) begin
				case ($urandom_range(0, 4))
					0: sv = '0;
					1: sv = '1;
					2: sv = SOFT_RESET;
					3: sv = SOFT_W'({$urandom, $urandom} >> $urandom_range(0, 40));
					default: sv = SOFT_W'({$urandom, $urandom});
				endcase
				set_soft(sv);
				tx_max_gap = $urandom_range(0, 1) ? 10 : 0;
				rx_max_gap = $urandom_range(0, 1) ? 10 : 0;
			end
			case ($urandom_range(0, 9))
				0: begin
					// noise: unknown function or sources with no fresh load
					if ($urandom_range(0, 1))
						send(FUNC_NONE, rand48(), rand48(), rand48(), rand48(), rand48(),
							rand48(), $urandom);
					else
						send_source($urandom_range(0, 1) ? FUNC_ADD : FUNC_EMIT);
				end
				default: begin
					load_target(pick_coord('0), pick_coord('0), pick_coord('0),
						pick_coord('0), pick_coord('0), pick_coord('0));
					repeat ($urandom_range(0, 3)) send_source(FUNC_ADD);
					send_source(FUNC_EMIT);
					if ($urandom_range(0, 4) == 0) begin
						repeat ($urandom_range(0, 2)) send_source(FUNC_ADD);
						send_source(FUNC_EMIT);
					end
				end
			endcase
		end

		// drain and decide
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### files.f
sv/gfja_pkg.sv
sv/gfja_ifs.sv
sv/gfja_mul.sv
sv/gfja_div.sv
sv/gfja_sqrt.sv
sv/gfja_dp.sv
sv/gfja_ctrl.sv
sv/gravity_force_jerk_accumulator_unit.sv
tb/gfja_checker.sv
tb/tb_gravity_force_jerk_accumulator_unit.sv
